// ===== rtl/core/nrs_pkg.sv =====
// package for the nack receive scoreboard: sizes, state codes and register indexes
package nrs_pkg;

  // bitmap geometry
  localparam int unsigned MAX_PACKETS   = 4096;
  localparam int unsigned PAYLOAD_BYTES = 1450;
  localparam int unsigned SEQ_W         = $clog2(MAX_PACKETS);
  localparam int unsigned CNT_W         = SEQ_W + 1;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned OFF_W         = $clog2(WORD_W);
  localparam int unsigned ROWS          = MAX_PACKETS / WORD_W;
  localparam int unsigned ROW_W         = $clog2(ROWS);

  // field widths
  localparam int unsigned TOTAL_W  = 13;
  localparam int unsigned LASTB_W  = 11;
  localparam int unsigned SEQIN_W  = 32;
  localparam int unsigned OFFSET_W = 23;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned NSEQ_W   = 12;

  // fraction compares scaled by ten; divide by ten via reciprocal
  localparam int unsigned MUL_W       = CNT_W + 3;
  localparam int unsigned RECIP_W     = 16;
  localparam int unsigned RECIP_10    = 52429;
  localparam int unsigned RECIP_SHIFT = 19;

  localparam int unsigned TOTAL_RESET = 1;
  localparam int unsigned LASTB_RESET = 1450;

  typedef enum logic {
    CFG_TOTAL      = 1'b0,
    CFG_LAST_BYTES = 1'b1
  } nrs_cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PKT,
    ST_PFIN,
    ST_TBOUND,
    ST_TLIM,
    ST_WRD,
    ST_WCHK,
    ST_SRD,
    ST_SCHK,
    ST_OUT
  } nrs_state_e;

endpackage

// ===== rtl/core/nack_receive_scoreboard.sv =====
// nack receive scoreboard: received bitmap in memory, window advance and nack scan
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------------
//  in      | input     | in_valid_i/in_stall_o  | command_i, seq_number_i
//  out     | output    | out_valid_o/out_stall_i| new_packet_o .. nack_active_o
//  cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// a packet beat reads its bitmap word as it is taken, then does the read-modify-write,
// then the done and enable compares, then loads the output register
// a tick beat goes straight on to the output register while nack is off or the
// transfer is done, else it computes the extension and the window limit, advances
// the window start word by word over the bitmap and then scans for the next missing
// packet; the window advance and the scan read one bitmap word at a time from the
// single-port bitmap memory with its registered read, each read followed by a check
// the bitmap starts cleared after reset through a valid bit per memory row
// the next beat is taken while a result still waits under out_stall_i
module nack_receive_scoreboard
  import nrs_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [TOTAL_W-1:0]        cfg_data_i,
  // input beats
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      command_i,
  input  logic signed [SEQIN_W-1:0] seq_number_i,
  // output beats
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      new_packet_o,
  output logic [OFFSET_W-1:0]       write_offset_o,
  output logic [LEN_W-1:0]          write_length_o,
  output logic                      transfer_done_o,
  output logic                      nack_valid_o,
  output logic [NSEQ_W-1:0]         nack_seq_o,
  output logic                      nack_active_o
);

  // first set bit of a word, WORD_W when none
  function automatic logic [OFF_W:0] first_set(input logic [WORD_W-1:0] v);
    logic [OFF_W:0] pos;
    pos = (OFF_W+1)'(WORD_W);
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (v[k]) begin
        pos = (OFF_W+1)'(k);
      end
    end
    return pos;
  endfunction

  nrs_state_e state_q, state_d;

  // configuration registers
  logic [TOTAL_W-1:0] total_q;
  logic [LASTB_W-1:0] lastb_q;
  logic [CNT_W-1:0]   eff_total;

  // latched input beat
  logic             cmd_q, cmd_d;
  logic             in_range_q, in_range_d;
  logic [SEQ_W-1:0] idx_q, idx_d;

  // scoreboard state
  logic [CNT_W-1:0] count_q, count_d;
  logic [SEQ_W-1:0] highest_q, highest_d;
  logic [CNT_W-1:0] ws_q, ws_d;
  logic [CNT_W-1:0] sp_q, sp_d;
  logic             nack_en_q, nack_en_d;
  logic [CNT_W-1:0] ext_q, ext_d;
  logic [CNT_W-1:0] lim_q, lim_d;

  // result being built
  logic                res_new_q, res_new_d;
  logic [OFFSET_W-1:0] res_off_q, res_off_d;
  logic [LEN_W-1:0]    res_len_q, res_len_d;
  logic                res_done_q, res_done_d;
  logic                res_nv_q, res_nv_d;
  logic [NSEQ_W-1:0]   res_nseq_q, res_nseq_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic                out_new_q, out_new_d;
  logic [OFFSET_W-1:0] out_off_q, out_off_d;
  logic [LEN_W-1:0]    out_len_q, out_len_d;
  logic                out_done_q, out_done_d;
  logic                out_nv_q, out_nv_d;
  logic [NSEQ_W-1:0]   out_nseq_q, out_nseq_d;
  logic                out_act_q, out_act_d;

  // bitmap memory, one row valid bit stands in for clearing
  logic [WORD_W-1:0] map_mem [ROWS];
  logic [ROWS-1:0]   rowv_q;
  logic              rowv_rd_q;
  logic [WORD_W-1:0] rdata_q;
  logic [ROW_W-1:0]  rd_addr;
  logic              wr_en;
  logic [ROW_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] word;

  // arithmetic helpers
  logic [MUL_W-1:0]         h10, t8, t7, t3;
  logic [MUL_W+RECIP_W-1:0] ext_prod;
  logic [OFFSET_W-1:0]      pkt_offset;
  logic [CNT_W-1:0]         bound1;
  logic [OFF_W:0]           run;
  logic [CNT_W-1:0]         wnext;
  logic [WORD_W-1:0]        zeros;
  logic [OFF_W:0]           zpos;
  logic [CNT_W-1:0]         found_idx;
  logic                     done_now;

  assign eff_total = (total_q > TOTAL_W'(MAX_PACKETS)) ? CNT_W'(MAX_PACKETS)
                                                      : CNT_W'(total_q);
  assign word      = rowv_rd_q ? rdata_q : '0;

  assign h10 = (MUL_W'(highest_q) << 3) + (MUL_W'(highest_q) << 1);
  assign t8  = MUL_W'(eff_total) << 3;
  assign t7  = t8 - MUL_W'(eff_total);
  assign t3  = (MUL_W'(eff_total) << 1) + MUL_W'(eff_total);
  // floor(total * 3 / 10) by reciprocal, exact for these widths
  assign ext_prod = (MUL_W+RECIP_W)'(t3) * (MUL_W+RECIP_W)'(RECIP_10);

  assign pkt_offset = OFFSET_W'(idx_q) * OFFSET_W'(PAYLOAD_BYTES);
  assign bound1     = CNT_W'(highest_q) + ext_q + CNT_W'(1);

  // window walk: run of set bits from the window start
  assign run   = first_set(~(word >> ws_q[OFF_W-1:0]));
  assign wnext = ws_q + CNT_W'(run);

  // scan: first clear bit at or above the scan position
  assign zeros     = ~word & ({WORD_W{1'b1}} << sp_q[OFF_W-1:0]);
  assign zpos      = first_set(zeros);
  assign found_idx = {sp_q[CNT_W-1:OFF_W], zpos[OFF_W-1:0]};
  assign done_now  = (count_q == eff_total);

  assign in_stall_o = (state_q != ST_IDLE);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_W'(TOTAL_RESET);
      lastb_q <= LASTB_W'(LASTB_RESET);
    end else if (cfg_we_i) begin
      unique case (nrs_cfg_e'(cfg_idx_i))
        CFG_TOTAL:      total_q <= cfg_data_i;
        CFG_LAST_BYTES: lastb_q <= cfg_data_i[LASTB_W-1:0];
      endcase
    end
  end

  // next state and datapath
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    in_range_d  = in_range_q;
    idx_d       = idx_q;
    count_d     = count_q;
    highest_d   = highest_q;
    ws_d        = ws_q;
    sp_d        = sp_q;
    nack_en_d   = nack_en_q;
    ext_d       = ext_q;
    lim_d       = lim_q;
    res_new_d   = res_new_q;
    res_off_d   = res_off_q;
    res_len_d   = res_len_q;
    res_done_d  = res_done_q;
    res_nv_d    = res_nv_q;
    res_nseq_d  = res_nseq_q;
    out_valid_d = out_valid_q;
    out_new_d   = out_new_q;
    out_off_d   = out_off_q;
    out_len_d   = out_len_q;
    out_done_d  = out_done_q;
    out_nv_d    = out_nv_q;
    out_nseq_d  = out_nseq_q;
    out_act_d   = out_act_q;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = idx_q[SEQ_W-1:OFF_W];
    wr_data     = word | (WORD_W'(1) << idx_q[OFF_W-1:0]);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d      = command_i;
          in_range_d = (seq_number_i[SEQIN_W-1:CNT_W] == '0) &&
                       (seq_number_i[CNT_W-1:0] < eff_total);
          idx_d      = seq_number_i[SEQ_W-1:0];
          rd_addr    = seq_number_i[SEQ_W-1:OFF_W];
          state_d    = command_i ? ST_TBOUND : ST_PKT;
        end
      end

      ST_PKT: begin
        res_new_d  = 1'b0;
        res_off_d  = '0;
        res_len_d  = '0;
        res_nv_d   = 1'b0;
        res_nseq_d = '0;
        if (in_range_q && !word[idx_q[OFF_W-1:0]]) begin
          wr_en     = 1'b1;
          count_d   = count_q + CNT_W'(1);
          highest_d = (idx_q > highest_q) ? idx_q : highest_q;
          res_new_d = 1'b1;
          res_off_d = pkt_offset;
          res_len_d = (CNT_W'(idx_q) == eff_total - CNT_W'(1)) ? lastb_q
                                                               : LEN_W'(PAYLOAD_BYTES);
        end
        state_d = ST_PFIN;
      end

      ST_PFIN: begin
        res_done_d = done_now;
        if (!done_now && (h10 >= t8)) begin
          nack_en_d = 1'b1;
        end
        state_d = ST_OUT;
      end

      ST_TBOUND: begin
        res_new_d  = 1'b0;
        res_off_d  = '0;
        res_len_d  = '0;
        res_nv_d   = 1'b0;
        res_nseq_d = '0;
        res_done_d = done_now;
        if (nack_en_q && !done_now) begin
          ext_d   = (h10 > t7) ? ext_prod[RECIP_SHIFT +: CNT_W] : '0;
          state_d = ST_TLIM;
        end else begin
          state_d = ST_OUT;
        end
      end

      ST_TLIM: begin
        // window stops before bound + 1 or the total, whichever is lower
        lim_d   = (bound1 < eff_total) ? bound1 : eff_total;
        state_d = ST_WRD;
      end

      ST_WRD: begin
        if (ws_q < lim_q) begin
          rd_addr = ws_q[SEQ_W-1:OFF_W];
          state_d = ST_WCHK;
        end else begin
          state_d = ST_SRD;
        end
      end

      ST_WCHK: begin
        if (wnext >= lim_q) begin
          ws_d    = lim_q;
          state_d = ST_SRD;
        end else if ((OFF_W+1)'(ws_q[OFF_W-1:0]) + run == (OFF_W+1)'(WORD_W)) begin
          // rest of the word all received, go on with the next word
          ws_d    = wnext;
          state_d = ST_WRD;
        end else begin
          ws_d    = wnext;
          state_d = ST_SRD;
        end
      end

      ST_SRD: begin
        if (sp_q < eff_total) begin
          rd_addr = sp_q[SEQ_W-1:OFF_W];
          state_d = ST_SCHK;
        end else begin
          sp_d    = ws_q;
          state_d = ST_OUT;
        end
      end

      ST_SCHK: begin
        if (!zpos[OFF_W]) begin
          if (found_idx < eff_total) begin
            res_nv_d   = 1'b1;
            res_nseq_d = found_idx[NSEQ_W-1:0];
            sp_d       = (found_idx == eff_total - CNT_W'(1)) ? ws_q
                                                              : found_idx + CNT_W'(1);
          end else begin
            sp_d = ws_q;
          end
          state_d = ST_OUT;
        end else begin
          sp_d    = {sp_q[CNT_W-1:OFF_W] + (CNT_W-OFF_W)'(1), OFF_W'(0)};
          state_d = ST_SRD;
        end
      end

      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_new_d   = res_new_q;
          out_off_d   = res_off_q;
          out_len_d   = res_len_q;
          out_done_d  = res_done_q;
          out_nv_d    = res_nv_q;
          out_nseq_d  = res_nseq_q;
          out_act_d   = nack_en_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      highest_q   <= '0;
      ws_q        <= '0;
      sp_q        <= '0;
      nack_en_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      highest_q   <= highest_d;
      ws_q        <= ws_d;
      sp_q        <= sp_d;
      nack_en_q   <= nack_en_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    in_range_q <= in_range_d;
    idx_q      <= idx_d;
    ext_q      <= ext_d;
    lim_q      <= lim_d;
    res_new_q  <= res_new_d;
    res_off_q  <= res_off_d;
    res_len_q  <= res_len_d;
    res_done_q <= res_done_d;
    res_nv_q   <= res_nv_d;
    res_nseq_q <= res_nseq_d;
    out_new_q  <= out_new_d;
    out_off_q  <= out_off_d;
    out_len_q  <= out_len_d;
    out_done_q <= out_done_d;
    out_nv_q   <= out_nv_d;
    out_nseq_q <= out_nseq_d;
    out_act_q  <= out_act_d;
  end

  // bitmap memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    rdata_q <= map_mem[rd_addr];
  end

  // row valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rowv_q    <= '0;
      rowv_rd_q <= 1'b0;
    end else begin
      if (wr_en) begin
        rowv_q[wr_addr] <= 1'b1;
      end
      rowv_rd_q <= rowv_q[rd_addr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign new_packet_o    = out_new_q;
  assign write_offset_o  = out_off_q;
  assign write_length_o  = out_len_q;
  assign transfer_done_o = out_done_q;
  assign nack_valid_o    = out_nv_q;
  assign nack_seq_o      = out_nseq_q;
  assign nack_active_o   = out_act_q;

`ifndef SYNTHESIS
  // window start only moves forward
  a_ws_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ws_q >= $past(ws_q))
    else $error("window start moved backward");

  // nack generation never switches off once enabled
  a_nack_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nack_en_q |=> nack_en_q)
    else $error("nack enable dropped");

  // distinct packet count cannot pass the bitmap size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_PACKETS))
    else $error("received count beyond bitmap size");

  // a nack beat never carries a file write
  a_nack_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_nv_q |-> !out_new_q && (out_len_q == '0))
    else $error("nack beat carries a write");

  // bitmap is written only while a packet is being marked
  a_write_in_pkt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_PKT) && !cmd_q && in_range_q)
    else $error("bitmap write outside packet marking");
`endif

endmodule
